[rtl/core/sta_pkg.sv]
// Shared constants, tables and types for the sphere texel address core.
package sta_pkg;

  localparam int MAX_TEX_DIM_DEF  = 4096;
  localparam int ANGLE_STAGES_DEF = 16;
  localparam int ATAN_LUT_N       = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int COORD_W    = 32;
  localparam int DIM_W      = 13;
  localparam int IDX_W      = 12;
  localparam int MAG_W      = 31;
  localparam int ROOT_W     = 32;
  localparam int RAD_W      = 64;
  localparam int ANG_W      = 32;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 3'd4;

  localparam logic [DIM_W-1:0] DIM_RESET = 13'd256;

  // angles: unsigned fraction of a full turn, 2^32 = one turn
  localparam logic [ANG_W-1:0] TURN_QUARTER = 32'h4000_0000;
  localparam logic [ANG_W-1:0] TURN_HALF    = 32'h8000_0000;

  localparam logic [ANG_W-1:0] ATAN_TURNS [ATAN_LUT_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // per-request sideband carried alongside the square root
  typedef struct packed {
    logic [MAG_W-1:0] mx;
    logic [MAG_W-1:0] my;
    logic [MAG_W-1:0] mz;
    logic             yneg;
    logic             xpos;
    logic             zneg;
    logic             ctr;
  } side_t;

  // per-lane flags through the angle pipeline
  typedef struct packed {
    logic zero_both;
    logic b_zero;
    logic a_zero;
    logic a_neg;
    logic b_neg;
  } lane_flag_t;

endpackage

[rtl/core/sta_isqrt.sv]
// Pipelined floor integer square root, one result bit per stage.
module sta_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [sta_pkg::RAD_W-1:0]  in_n,
  input  sta_pkg::side_t             in_side,
  output logic                       out_valid,
  output logic [sta_pkg::ROOT_W-1:0] out_root,
  output sta_pkg::side_t             out_side
);

  localparam int STEPS = sta_pkg::ROOT_W;
  localparam int REM_W = sta_pkg::ROOT_W + 2;
  localparam int RW    = sta_pkg::ROOT_W;
  localparam int NW    = sta_pkg::RAD_W;

  logic                st_valid [STEPS];
  logic [REM_W-1:0]    st_rem   [STEPS];
  logic [RW-1:0]       st_root  [STEPS];
  logic [NW-1:0]       st_n     [STEPS];
  sta_pkg::side_t      st_side  [STEPS];

  genvar i;
  generate
    for (i = 0; i < STEPS; i++) begin : g_step
      logic               cur_valid;
      logic [REM_W-1:0]   cur_rem;
      logic [RW-1:0]      cur_root;
      logic [NW-1:0]      cur_n;
      sta_pkg::side_t     cur_side;
      logic [REM_W+1:0]   rem_sh;
      logic [REM_W+1:0]   trial;
      logic               take;

      if (i == 0) begin : g_first
        assign cur_valid = in_valid;
        assign cur_rem   = '0;
        assign cur_root  = '0;
        assign cur_n     = in_n;
        assign cur_side  = in_side;
      end else begin : g_rest
        assign cur_valid = st_valid[i-1];
        assign cur_rem   = st_rem[i-1];
        assign cur_root  = st_root[i-1];
        assign cur_n     = st_n[i-1];
        assign cur_side  = st_side[i-1];
      end

      assign rem_sh = {cur_rem, cur_n[NW-1 -: 2]};
      assign trial  = {2'b00, cur_root, 2'b01};
      assign take   = rem_sh >= trial;

      always_ff @(posedge clk) begin
        if (rst) begin
          st_valid[i] <= 1'b0;
        end else if (en) begin
          st_valid[i] <= cur_valid;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          st_rem[i]  <= take ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
          st_root[i] <= {cur_root[RW-2:0], take};
          st_n[i]    <= {cur_n[NW-3:0], 2'b00};
          st_side[i] <= cur_side;
        end
      end
    end
  endgenerate

  assign out_valid = st_valid[STEPS-1];
  assign out_root  = st_root[STEPS-1];
  assign out_side  = st_side[STEPS-1];

endmodule

[rtl/core/sta_atan.sv]
// Two-lane pipelined vectoring CORDIC: atan2 in turns with quadrant fix-up.
module sta_atan #(
  parameter int ANGLE_STAGES = sta_pkg::ANGLE_STAGES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic                                  in_ctr,
  input  logic [1:0][sta_pkg::ROOT_W-1:0]       in_b_mag,
  input  logic [1:0]                            in_b_neg,
  input  logic [1:0][sta_pkg::ROOT_W-1:0]       in_a_mag,
  input  logic [1:0]                            in_a_neg,
  output logic                                  out_valid,
  output logic                                  out_ctr,
  output logic [1:0][sta_pkg::ANG_W-1:0]        out_angle
);

  localparam int NS       = (ANGLE_STAGES < sta_pkg::ATAN_LUT_N) ?
                            ANGLE_STAGES : sta_pkg::ATAN_LUT_N;
  localparam int MW       = sta_pkg::ROOT_W;
  localparam int POS_W    = $clog2(MW);
  localparam int NORM_MSB = 29;
  localparam int CW       = 34;
  localparam int ZW       = sta_pkg::ANG_W + 1;

  // normalise, stage 1: leading one of the larger operand
  logic                      n1_valid;
  logic                      n1_ctr;
  logic [1:0][MW-1:0]        n1_a;
  logic [1:0][MW-1:0]        n1_b;
  logic [1:0][POS_W-1:0]     n1_pos;
  sta_pkg::lane_flag_t [1:0] n1_flag;

  logic [1:0][POS_W-1:0]     pos_c;
  sta_pkg::lane_flag_t [1:0] flag_c;

  always_comb begin
    logic [MW-1:0] mx;
    for (int l = 0; l < 2; l++) begin
      mx = (in_a_mag[l] > in_b_mag[l]) ? in_a_mag[l] : in_b_mag[l];
      pos_c[l] = '0;
      for (int k = 0; k < MW; k++) begin
        if (mx[k]) pos_c[l] = POS_W'(k);
      end
      flag_c[l].b_zero    = in_b_mag[l] == '0;
      flag_c[l].a_zero    = in_a_mag[l] == '0;
      flag_c[l].zero_both = (in_b_mag[l] == '0) && (in_a_mag[l] == '0);
      flag_c[l].a_neg     = in_a_neg[l];
      flag_c[l].b_neg     = in_b_neg[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n1_valid <= 1'b0;
    end else if (en) begin
      n1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_ctr  <= in_ctr;
      n1_a    <= in_a_mag;
      n1_b    <= in_b_mag;
      n1_pos  <= pos_c;
      n1_flag <= flag_c;
    end
  end

  // normalise, stage 2: shift so the larger lies in [2^29, 2^30)
  logic                      c_valid [NS+1];
  logic                      c_ctr   [NS+1];
  logic signed [CW-1:0]      c_x     [NS+1][2];
  logic signed [CW-1:0]      c_y     [NS+1][2];
  logic signed [ZW-1:0]      c_z     [NS+1][2];
  sta_pkg::lane_flag_t       c_flag  [NS+1][2];

  logic [1:0][MW-1:0]        a_sh;
  logic [1:0][MW-1:0]        b_sh;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (n1_pos[l] > POS_W'(NORM_MSB)) begin
        a_sh[l] = n1_a[l] >> POS_W'(n1_pos[l] - POS_W'(NORM_MSB));
        b_sh[l] = n1_b[l] >> POS_W'(n1_pos[l] - POS_W'(NORM_MSB));
      end else begin
        a_sh[l] = n1_a[l] << POS_W'(POS_W'(NORM_MSB) - n1_pos[l]);
        b_sh[l] = n1_b[l] << POS_W'(POS_W'(NORM_MSB) - n1_pos[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid[0] <= 1'b0;
    end else if (en) begin
      c_valid[0] <= n1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_ctr[0] <= n1_ctr;
      for (int l = 0; l < 2; l++) begin
        c_x[0][l]    <= CW'({1'b0, a_sh[l][NORM_MSB:0]});
        c_y[0][l]    <= CW'({1'b0, b_sh[l][NORM_MSB:0]});
        c_z[0][l]    <= '0;
        c_flag[0][l] <= n1_flag[l];
      end
    end
  end

  // rotation stages
  genvar i;
  generate
    for (i = 0; i < NS; i++) begin : g_rot
      logic signed [ZW-1:0] step_ang;
      assign step_ang = signed'(ZW'(sta_pkg::ATAN_TURNS[i]));

      always_ff @(posedge clk) begin
        if (rst) begin
          c_valid[i+1] <= 1'b0;
        end else if (en) begin
          c_valid[i+1] <= c_valid[i];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          c_ctr[i+1] <= c_ctr[i];
          for (int l = 0; l < 2; l++) begin
            c_flag[i+1][l] <= c_flag[i][l];
            if (!c_y[i][l][CW-1]) begin
              c_x[i+1][l] <= c_x[i][l] + (c_y[i][l] >>> i);
              c_y[i+1][l] <= c_y[i][l] - (c_x[i][l] >>> i);
              c_z[i+1][l] <= c_z[i][l] + step_ang;
            end else begin
              c_x[i+1][l] <= c_x[i][l] - (c_y[i][l] >>> i);
              c_y[i+1][l] <= c_y[i][l] + (c_x[i][l] >>> i);
              c_z[i+1][l] <= c_z[i][l] - step_ang;
            end
          end
        end
      end
    end
  endgenerate

  // clamp, axis cases and quadrant
  logic [1:0][sta_pkg::ANG_W-1:0] ang_c;

  always_comb begin
    logic [sta_pkg::ANG_W-1:0] th;
    sta_pkg::lane_flag_t       f;
    for (int l = 0; l < 2; l++) begin
      f = c_flag[NS][l];
      if (f.b_zero) begin
        th = '0;
      end else if (f.a_zero) begin
        th = sta_pkg::TURN_QUARTER;
      end else if (c_z[NS][l][ZW-1]) begin
        th = '0;
      end else if (c_z[NS][l] > signed'(ZW'(sta_pkg::TURN_QUARTER))) begin
        th = sta_pkg::TURN_QUARTER;
      end else begin
        th = c_z[NS][l][sta_pkg::ANG_W-1:0];
      end
      if (f.zero_both) begin
        ang_c[l] = '0;
      end else if (!f.a_neg && !f.b_neg) begin
        ang_c[l] = th;
      end else if (f.a_neg && !f.b_neg) begin
        ang_c[l] = sta_pkg::TURN_HALF - th;
      end else if (f.a_neg) begin
        ang_c[l] = sta_pkg::TURN_HALF + th;
      end else begin
        ang_c[l] = '0 - th;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_valid[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctr   <= c_ctr[NS];
      out_angle <= ang_c;
    end
  end

endmodule

[rtl/core/sphere_texel_address_core.sv]
// Top level: centre offset, radius, polar/azimuth angles and texel indices.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  config  | in        | cfg_we             | cfg_index, cfg_data
//  point   | in        | in_valid, in_stall | point_x, point_y, point_z
//  texel   | out       | out_valid,out_stall| tex_row, tex_col, at_center
//
// One request per cycle unless the pipeline is frozen (below); the depth is set
// by the 32-stage square root and the CORDIC stage count.
// The whole pipeline advances together; it freezes only while a result sits
// in the output register and out_stall is high, and in_stall follows that.
// Synchronous reset empties every stage and loads the register defaults.
module sphere_texel_address_core #(
  parameter int MAX_TEX_DIM  = sta_pkg::MAX_TEX_DIM_DEF,
  parameter int ANGLE_STAGES = sta_pkg::ANGLE_STAGES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [sta_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [sta_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [sta_pkg::COORD_W-1:0]     point_x,
  input  logic signed [sta_pkg::COORD_W-1:0]     point_y,
  input  logic signed [sta_pkg::COORD_W-1:0]     point_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [sta_pkg::IDX_W-1:0]              tex_row,
  output logic [sta_pkg::IDX_W-1:0]              tex_col,
  output logic                                   at_center
);

  localparam int CWD   = sta_pkg::COORD_W;
  localparam int DW    = CWD + 1;
  localparam int MW    = sta_pkg::MAG_W;
  localparam int DIMW  = sta_pkg::DIM_W;
  localparam int AW    = sta_pkg::ANG_W;
  localparam int PW    = AW + DIMW;
  localparam int SQW   = 2 * MW;

  // configuration
  logic [CWD-1:0]  center_x, center_y, center_z;
  logic [DIMW-1:0] tex_width, tex_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x   <= '0;
      center_y   <= '0;
      center_z   <= '0;
      tex_width  <= sta_pkg::DIM_RESET;
      tex_height <= sta_pkg::DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sta_pkg::REG_CENTER_X:   center_x   <= cfg_data[CWD-1:0];
        sta_pkg::REG_CENTER_Y:   center_y   <= cfg_data[CWD-1:0];
        sta_pkg::REG_CENTER_Z:   center_z   <= cfg_data[CWD-1:0];
        sta_pkg::REG_TEX_WIDTH:  tex_width  <= cfg_data[DIMW-1:0];
        sta_pkg::REG_TEX_HEIGHT: tex_height <= cfg_data[DIMW-1:0];
        default: ;
      endcase
    end
  end

  logic [DIMW-1:0] w_dim, h_dim;

  always_comb begin
    w_dim = (tex_width == '0) ? DIMW'(1) : tex_width;
    if (32'(w_dim) > MAX_TEX_DIM) w_dim = DIMW'(MAX_TEX_DIM);
    h_dim = (tex_height == '0) ? DIMW'(1) : tex_height;
    if (32'(h_dim) > MAX_TEX_DIM) h_dim = DIMW'(MAX_TEX_DIM);
  end

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // stage A: offset from centre
  logic                 a_valid;
  logic signed [DW-1:0] a_dx, a_dy, a_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dx <= {point_x[CWD-1], point_x} - signed'({center_x[CWD-1], center_x});
      a_dy <= {point_y[CWD-1], point_y} - signed'({center_y[CWD-1], center_y});
      a_dz <= {point_z[CWD-1], point_z} - signed'({center_z[CWD-1], center_z});
    end
  end

  // stage B: magnitudes, halved together when any reaches 2^31
  logic           b_valid;
  sta_pkg::side_t b_side;
  sta_pkg::side_t side_c;

  always_comb begin
    logic [DW-1:0] ax, ay, az;
    logic          huge;
    ax = a_dx[DW-1] ? DW'(-a_dx) : DW'(a_dx);
    ay = a_dy[DW-1] ? DW'(-a_dy) : DW'(a_dy);
    az = a_dz[DW-1] ? DW'(-a_dz) : DW'(a_dz);
    huge = (ax[DW-1 -: 2] != 2'b00) || (ay[DW-1 -: 2] != 2'b00) ||
           (az[DW-1 -: 2] != 2'b00);
    side_c.mx   = huge ? ax[MW:1] : ax[MW-1:0];
    side_c.my   = huge ? ay[MW:1] : ay[MW-1:0];
    side_c.mz   = huge ? az[MW:1] : az[MW-1:0];
    side_c.xpos = !a_dx[DW-1] && (side_c.mx != '0);
    side_c.yneg = a_dy[DW-1] && (side_c.my != '0);
    side_c.zneg = a_dz[DW-1] && (side_c.mz != '0);
    side_c.ctr  = (a_dx == '0) && (a_dy == '0) && (a_dz == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_side <= side_c;
    end
  end

  // stage C: squares
  logic           c_valid;
  logic [SQW-1:0] c_sqx, c_sqz;
  sta_pkg::side_t c_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_sqx  <= b_side.mx * b_side.mx;
      c_sqz  <= b_side.mz * b_side.mz;
      c_side <= b_side;
    end
  end

  // stage D: x^2 + z^2
  logic                        d_valid;
  logic [sta_pkg::RAD_W-1:0]   d_n;
  sta_pkg::side_t              d_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_n    <= sta_pkg::RAD_W'(c_sqx) + sta_pkg::RAD_W'(c_sqz);
      d_side <= c_side;
    end
  end

  // radius
  logic                       r_valid;
  logic [sta_pkg::ROOT_W-1:0] r_root;
  sta_pkg::side_t             r_side;

  sta_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .in_n      (d_n),
    .in_side   (d_side),
    .out_valid (r_valid),
    .out_root  (r_root),
    .out_side  (r_side)
  );

  // lane 0: polar angle atan2(r, y); lane 1: azimuth atan2(x, z) with signs
  logic [1:0][sta_pkg::ROOT_W-1:0] b_mag, a_mag;
  logic [1:0]                      b_neg, a_neg;

  assign b_mag[0] = r_root;
  assign b_neg[0] = 1'b0;
  assign a_mag[0] = sta_pkg::ROOT_W'(r_side.my);
  assign a_neg[0] = r_side.yneg;
  assign b_mag[1] = sta_pkg::ROOT_W'(r_side.mx);
  assign b_neg[1] = r_side.xpos;
  assign a_mag[1] = sta_pkg::ROOT_W'(r_side.mz);
  assign a_neg[1] = r_side.zneg;

  logic               g_valid;
  logic               g_ctr;
  logic [1:0][AW-1:0] g_angle;

  sta_atan #(
    .ANGLE_STAGES (ANGLE_STAGES)
  ) u_atan (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (r_valid),
    .in_ctr    (r_side.ctr),
    .in_b_mag  (b_mag),
    .in_b_neg  (b_neg),
    .in_a_mag  (a_mag),
    .in_a_neg  (a_neg),
    .out_valid (g_valid),
    .out_ctr   (g_ctr),
    .out_angle (g_angle)
  );

  // stage M: scale angles by texture size
  logic          m_valid;
  logic          m_ctr;
  logic [PW-1:0] m_row_prod, m_col_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_ctr      <= g_ctr;
      m_row_prod <= PW'(g_angle[0]) * PW'(h_dim);
      m_col_prod <= PW'(g_angle[1]) * PW'(w_dim);
    end
  end

  // output register: floor and saturate
  logic [PW-AW:0]   row_full;
  logic [PW-AW-1:0] col_full;
  logic [PW-AW:0]   row_sat;
  logic [PW-AW-1:0] col_sat;

  always_comb begin
    row_full = m_row_prod[PW-1:AW-1];
    col_full = m_col_prod[PW-1:AW];
    row_sat  = (row_full > (PW-AW+1)'(h_dim - 1'b1)) ? (PW-AW+1)'(h_dim - 1'b1) : row_full;
    col_sat  = (col_full > (PW-AW)'(w_dim - 1'b1)) ? (PW-AW)'(w_dim - 1'b1) : col_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      at_center <= m_ctr;
      tex_row   <= m_ctr ? '0 : row_sat[sta_pkg::IDX_W-1:0];
      tex_col   <= m_ctr ? '0 : col_sat[sta_pkg::IDX_W-1:0];
    end
  end

`ifndef NO_ASSERTIONS
  a_centre_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && at_center |-> tex_row == '0 && tex_col == '0)
    else $error("centre request with nonzero indices");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && h_dim <= DIMW'(4096) |-> {1'b0, tex_row} < h_dim)
    else $error("row beyond texture height");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && w_dim <= DIMW'(4096) |-> {1'b0, tex_col} < w_dim)
    else $error("column beyond texture width");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !m_valid && !a_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule
